/* rtl/mfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix flip/rotate engine package
// Operation and transform codes and shared types of the flip/rotate engine.
// ----------------------------------------------------------------------------
package mfr_pkg;

    typedef logic [7:0] t_coord;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_TRANSFORM = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    localparam logic [2:0] TR_VFLIP   = 3'd1;
    localparam logic [2:0] TR_HFLIP   = 3'd2;
    localparam logic [2:0] TR_ROT_CW  = 3'd3;
    localparam logic [2:0] TR_ROT_CCW = 3'd4;
    localparam logic [2:0] TR_QUAD_CW = 3'd5;
    localparam logic [2:0] TR_QUAD_CCW = 3'd6;

endpackage

`default_nettype wire

/* rtl/mfr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/matrix_flip_rotate_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix flip/rotate engine
// Holds a 2-D array of words and applies flips, rotations and quadrant
// shifts in place through a scratch copy of the array.
// ----------------------------------------------------------------------------
// A write, a rejected read or an item without effect gives its strobe in the
// cycle after the transfer; an in-range read first passes the read state.
// A transform runs one pass that copies the array into the scratch memory
// and one pass that writes it back, one element per cycle.
// The block takes no item while busy is high; results cannot be stalled.
// Reset sets the dimensions to their defaults; memory contents are kept.
// ----------------------------------------------------------------------------
module matrix_flip_rotate_engine
    import mfr_pkg::*;
#(
    parameter int MAX_DIM    = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_done,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [6:0]        i_row_index,
    input  wire logic [6:0]        i_col_index,
    input  wire logic signed [31:0] i_write_value,
    input  wire logic [2:0]        i_transform_code,
    output logic signed [31:0]     o_read_value,
    output logic [7:0]             o_current_rows,
    output logic [7:0]             o_current_cols,
    output logic                   o_in_range
);

    localparam int AW         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH      = 1 << (2 * AW);
    localparam int DimMaxEven = MAX_DIM & ~1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    function automatic t_coord fit_dim(input logic [7:0] v);
        int d;
        d = int'(v & 8'hFE);
        if (d < 2) begin
            d = 2;
        end
        if (d > DimMaxEven) begin
            d = DimMaxEven;
        end
        return t_coord'(d);
    endfunction

    function automatic logic [2*AW-1:0] addr_of(input t_coord r, input t_coord c);
        logic [AW+7:0] tr;
        logic [AW+7:0] tc;
        tr = {{AW{1'b0}}, r};
        tc = {{AW{1'b0}}, c};
        return {tr[AW-1:0], tc[AW-1:0]};
    endfunction

    logic [2:0]            r_state;
    logic                  r_done;
    t_coord                r_rows;
    t_coord                r_cols;
    t_coord                r_n;
    t_coord                r_m;
    t_coord                r_i;
    t_coord                r_j;
    logic [2:0]            r_code;
    logic                  r_cp_v;
    logic                  r_mv_v;
    logic [2*AW-1:0]       r_src_addr;
    logic [2*AW-1:0]       r_dst_addr;
    logic signed [31:0]    r_read_value;
    logic                  r_ok;

    logic                  accept;
    logic                  acc_inside;
    logic [2*AW-1:0]       in_addr;
    logic [2*AW-1:0]       cur_addr;
    logic                  last_i;
    logic                  last_j;
    t_coord                hn;
    t_coord                hm;
    t_coord                di;
    t_coord                dj;
    logic                  arr_we;
    logic [2*AW-1:0]       arr_waddr;
    logic [DATA_WIDTH-1:0] arr_wdata;
    logic [2*AW-1:0]       arr_raddr;
    logic [DATA_WIDTH-1:0] arr_rdata;
    logic [DATA_WIDTH-1:0] scr_rdata;
    logic [DATA_WIDTH+31:0] wr_ext;
    logic [DATA_WIDTH+31:0] rd_ext;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && (r_state == S_IDLE);
    assign acc_inside = ({1'b0, i_row_index} < r_rows) && ({1'b0, i_col_index} < r_cols);
    assign in_addr    = addr_of({1'b0, i_row_index}, {1'b0, i_col_index});
    assign cur_addr   = addr_of(r_i, r_j);
    assign last_i     = (r_i == r_n - 8'd1);
    assign last_j     = (r_j == r_m - 8'd1);
    assign hn         = r_n >> 1;
    assign hm         = r_m >> 1;
    assign wr_ext     = {{DATA_WIDTH{1'b0}}, i_write_value};
    assign rd_ext     = {{32{arr_rdata[DATA_WIDTH-1]}}, arr_rdata};

    always_comb begin
        di = r_i;
        dj = r_j;
        case (r_code)
            TR_VFLIP: begin
                di = r_n - 8'd1 - r_i;
            end
            TR_HFLIP: begin
                dj = r_m - 8'd1 - r_j;
            end
            TR_ROT_CW: begin
                di = r_j;
                dj = r_n - 8'd1 - r_i;
            end
            TR_ROT_CCW: begin
                di = r_m - 8'd1 - r_j;
                dj = r_i;
            end
            TR_QUAD_CW: begin
                if (r_i < hn && r_j < hm) begin
                    dj = r_j + hm;
                end else if (r_i < hn) begin
                    di = r_i + hn;
                end else if (r_j >= hm) begin
                    dj = r_j - hm;
                end else begin
                    di = r_i - hn;
                end
            end
            TR_QUAD_CCW: begin
                if (r_i < hn && r_j < hm) begin
                    di = r_i + hn;
                end else if (r_i < hn) begin
                    dj = r_j - hm;
                end else if (r_j >= hm) begin
                    di = r_i - hn;
                end else begin
                    dj = r_j + hm;
                end
            end
            default: begin
                di = r_i;
                dj = r_j;
            end
        endcase
    end

    assign arr_we    = r_mv_v || (accept && (i_opcode == OP_WRITE) && acc_inside);
    assign arr_waddr = r_mv_v ? r_dst_addr : in_addr;
    assign arr_wdata = r_mv_v ? scr_rdata : wr_ext[DATA_WIDTH-1:0];
    assign arr_raddr = (r_state == S_COPY) ? cur_addr : in_addr;

    mfr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_array_ram (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (arr_waddr),
        .i_wdata (arr_wdata),
        .i_raddr (arr_raddr),
        .o_rdata (arr_rdata)
    );

    mfr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (r_cp_v),
        .i_waddr (r_src_addr),
        .i_wdata (arr_rdata),
        .i_raddr (cur_addr),
        .o_rdata (scr_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_src_addr <= cur_addr;
        r_dst_addr <= addr_of(di, dj);
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cp_v  <= 1'b0;
            r_mv_v  <= 1'b0;
            r_rows  <= fit_dim(8'd128);
            r_cols  <= fit_dim(8'd128);
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_done <= 1'b0;
            r_cp_v <= (r_state == S_COPY);
            r_mv_v <= (r_state == S_MOVE);
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        if (i_cfg_index) begin
                            r_cols <= fit_dim(i_cfg_data);
                        end else begin
                            r_rows <= fit_dim(i_cfg_data);
                        end
                    end
                    if (accept) begin
                        r_n          <= r_rows;
                        r_m          <= r_cols;
                        r_code       <= i_transform_code;
                        r_i          <= '0;
                        r_j          <= '0;
                        r_read_value <= '0;
                        r_ok         <= 1'b0;
                        case (i_opcode)
                            OP_WRITE: begin
                                r_ok   <= acc_inside;
                                r_done <= 1'b1;
                            end
                            OP_TRANSFORM: begin
                                if (i_transform_code >= TR_VFLIP
                                        && i_transform_code <= TR_QUAD_CCW) begin
                                    r_state <= S_COPY;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            OP_READ: begin
                                if (acc_inside) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_read_value <= rd_ext[31:0];
                    r_ok         <= 1'b1;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_COPY, S_MOVE: begin
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) begin
                            r_i     <= '0;
                            r_state <= (r_state == S_COPY) ? S_MOVE : S_FLUSH;
                        end else begin
                            r_i <= r_i + 8'd1;
                        end
                    end else begin
                        r_j <= r_j + 8'd1;
                    end
                end
                S_FLUSH: begin
                    if (r_code == TR_ROT_CW || r_code == TR_ROT_CCW) begin
                        r_rows <= r_m;
                        r_cols <= r_n;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_read_value   = r_read_value;
    assign o_current_rows = r_rows;
    assign o_current_cols = r_cols;
    assign o_in_range     = r_ok;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cp_v && r_mv_v))
        else $error("copy and move writes pending together");

    a_copy_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_v |-> $past(r_state) == S_COPY)
        else $error("scratch write outside copy pass");

    a_even_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rows[0] && !r_cols[0] && r_rows != 8'd0 && r_cols != 8'd0)
        else $error("dimension odd or zero");

    a_range_only_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_COPY) |=> !r_ok)
        else $error("in-range flag set during transform");

endmodule

`default_nettype wire

/* sim/matrix_flip_rotate_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix flip/rotate engine testbench
// Sends write, read and transform commands to the engine and compares every
// result with a behavioral copy of the array kept in the testbench.
// Dimension settings change between phases, and the sender idles at
// different rates.
// ----------------------------------------------------------------------------
module matrix_flip_rotate_engine_tb;
    import mfr_pkg::*;

    localparam int         DIM            = 128;
    localparam int         WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic       REG_ROWS       = 1'b0;
    localparam logic       REG_COLS       = 1'b1;

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         rows;
        logic [7:0]         cols;
        logic               in_range;
    } t_response;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               o_done;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [7:0]         i_cfg_data = 8'd0;
    logic [1:0]         i_opcode = OP_WRITE;
    logic [6:0]         i_row_index = 7'd0;
    logic [6:0]         i_col_index = 7'd0;
    logic signed [31:0] i_write_value = 32'sd0;
    logic [2:0]         i_transform_code = 3'd0;
    logic signed [31:0] o_read_value;
    logic [7:0]         o_current_rows;
    logic [7:0]         o_current_cols;
    logic               o_in_range;

    matrix_flip_rotate_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .o_done           (o_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_row_index      (i_row_index),
        .i_col_index      (i_col_index),
        .i_write_value    (i_write_value),
        .i_transform_code (i_transform_code),
        .o_read_value     (o_read_value),
        .o_current_rows   (o_current_rows),
        .o_current_cols   (o_current_cols),
        .o_in_range       (o_in_range)
    );

    always #4 i_clk = ~i_clk;

    logic [31:0] array_words [DIM][DIM];
    logic [31:0] scratch_words [DIM][DIM];
    bit          loaded [DIM][DIM];
    bit          scratch_loaded [DIM][DIM];
    int          rows_now = DIM;
    int          cols_now = DIM;

    t_response   pending_responses [$];
    t_response   oldest;
    int          fail_count = 0;
    int          checked_count = 0;
    int          idle_cycles = 0;
    int          sender_idle_pct = 0;
    int          item_count = 0;
    int          write_count = 0;
    int          read_count = 0;
    int          transform_count = 0;
    int          setting_count = 0;

    function automatic int fit_dimension(logic [7:0] value);
        int d;
        d = int'(value & 8'hFE);
        if (d < 2) d = 2;
        if (d > DIM) d = DIM;
        return d;
    endfunction

    function automatic void transform_array(logic [2:0] code);
        int n, m, hn, hm, di, dj;
        n = rows_now;
        m = cols_now;
        hn = n / 2;
        hm = m / 2;
        if (code < TR_VFLIP || code > TR_QUAD_CCW) return;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < m; j++) begin
                scratch_words[i][j] = array_words[i][j];
                scratch_loaded[i][j] = loaded[i][j];
            end
        end
        if (code == TR_ROT_CW || code == TR_ROT_CCW) begin
            rows_now = m;
            cols_now = n;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < m; j++) begin
                di = i;
                dj = j;
                case (code)
                    TR_VFLIP: di = n - 1 - i;
                    TR_HFLIP: dj = m - 1 - j;
                    TR_ROT_CW: begin
                        di = j;
                        dj = n - 1 - i;
                    end
                    TR_ROT_CCW: begin
                        di = m - 1 - j;
                        dj = i;
                    end
                    TR_QUAD_CW: begin
                        if (i < hn && j < hm) dj = j + hm;
                        else if (i < hn) di = i + hn;
                        else if (j >= hm) dj = j - hm;
                        else di = i - hn;
                    end
                    default: begin
                        if (i < hn && j < hm) di = i + hn;
                        else if (i < hn) dj = j - hm;
                        else if (j >= hm) di = i - hn;
                        else dj = j + hm;
                    end
                endcase
                array_words[di][dj] = scratch_words[i][j];
                loaded[di][dj] = scratch_loaded[i][j];
            end
        end
    endfunction

    function automatic t_response apply_item(logic [1:0] op, logic [6:0] row, logic [6:0] col,
                                             logic [31:0] value, logic [2:0] code);
        t_response r;
        bit in_bounds;
        r = '0;
        in_bounds = (int'(row) < rows_now) && (int'(col) < cols_now);
        case (op)
            OP_WRITE: begin
                if (in_bounds) begin
                    array_words[row][col] = value;
                    loaded[row][col] = 1'b1;
                    r.in_range = 1'b1;
                end
            end
            OP_TRANSFORM: transform_array(code);
            OP_READ: begin
                if (in_bounds) begin
                    r.value = array_words[row][col];
                    r.in_range = 1'b1;
                end
            end
            default: ;
        endcase
        r.rows = rows_now[7:0];
        r.cols = cols_now[7:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_responses.size() == 0) begin
                $error("result with no command outstanding");
                fail_count++;
            end else begin
                oldest = pending_responses.pop_front();
                checked_count++;
                if (o_read_value !== oldest.value) begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(oldest.value), o_read_value);
                    fail_count++;
                end
                if (o_current_rows !== oldest.rows) begin
                    $error("current_rows: expected %0d, got %0d", oldest.rows, o_current_rows);
                    fail_count++;
                end
                if (o_current_cols !== oldest.cols) begin
                    $error("current_cols: expected %0d, got %0d", oldest.cols, o_current_cols);
                    fail_count++;
                end
                if (o_in_range !== oldest.in_range) begin
                    $error("in_range: expected %0b, got %0b", oldest.in_range, o_in_range);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("FAIL matrix_flip_rotate_engine");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_item(input logic [1:0] op, input logic [6:0] row,
                              input logic [6:0] col, input logic [31:0] value,
                              input logic [2:0] code);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_row_index <= row;
        i_col_index <= col;
        i_write_value <= value;
        i_transform_code <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_responses.push_back(apply_item(op, row, col, value, code));
        item_count++;
        if (op == OP_WRITE) write_count++;
        if (op == OP_READ) read_count++;
        if (op == OP_TRANSFORM) transform_count++;
    endtask

    task automatic wait_until_settled();
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_dimensions(input logic [7:0] rows, input logic [7:0] cols);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        rows_now = fit_dimension(rows);
        i_cfg_index <= REG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        cols_now = fit_dimension(cols);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        setting_count++;
    endtask

    // Picks a loaded element inside the current dimensions; returns 0 if none.
    function automatic bit pick_loaded(output logic [6:0] row, output logic [6:0] col);
        int total, k;
        total = 0;
        row = '0;
        col = '0;
        for (int i = 0; i < rows_now; i++)
            for (int j = 0; j < cols_now; j++)
                if (loaded[i][j]) total++;
        if (total == 0) return 1'b0;
        k = $urandom_range(total - 1);
        for (int i = 0; i < rows_now; i++) begin
            for (int j = 0; j < cols_now; j++) begin
                if (loaded[i][j]) begin
                    if (k == 0) begin
                        row = i[6:0];
                        col = j[6:0];
                        return 1'b1;
                    end
                    k--;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic random_item();
        int          sel;
        logic [1:0]  op;
        logic [6:0]  row, col;
        logic [31:0] value;
        logic [2:0]  code;
        sel = $urandom_range(99);
        row = 7'($urandom_range(rows_now - 1));
        col = 7'($urandom_range(cols_now - 1));
        value = $urandom;
        code = 3'($urandom_range(7));
        op = OP_WRITE;
        if (sel < 20) begin
            op = OP_TRANSFORM;
            if ($urandom_range(9) != 0) code = 3'($urandom_range(1, 6));
        end else if (sel < 55) begin
            if (pick_loaded(row, col)) op = OP_READ;
        end else if (sel >= 90) begin
            op = 2'($urandom_range(3));
            row = 7'($urandom);
            col = 7'($urandom);
            if (op == OP_READ && int'(row) < rows_now && int'(col) < cols_now
                    && !loaded[row][col])
                op = OP_UNUSED;
        end
        issue_item(op, row, col, value, code);
    endtask

    task automatic test_full_size_corners();
        issue_item(OP_WRITE, 7'd0, 7'd0, 32'h8000_0000, TR_VFLIP);
        issue_item(OP_WRITE, 7'd127, 7'd127, 32'h7FFF_FFFF, 3'd0);
        issue_item(OP_WRITE, 7'd0, 7'd127, 32'hFFFF_FFFF, 3'd7);
        issue_item(OP_WRITE, 7'd127, 7'd0, 32'h0000_0000, 3'd0);
        issue_item(OP_READ, 7'd127, 7'd127, 32'h0, 3'd0);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_ROT_CW);
        issue_item(OP_READ, 7'd0, 7'd127, 32'h0, 3'd0);
        issue_item(OP_READ, 7'd127, 7'd0, 32'h0, 3'd0);
        wait_until_settled();
    endtask

    task automatic test_dimension_limits();
        set_dimensions(8'hFF, 8'h00);
        issue_item(OP_WRITE, 7'd3, 7'd127, 32'h1234_5678, 3'd0);
        issue_item(OP_READ, 7'd127, 7'd2, 32'h0, 3'd0);
        issue_item(OP_UNUSED, 7'd0, 7'd0, 32'hFFFF_FFFF, 3'd7);
        wait_until_settled();
    endtask

    task automatic test_transform_codes();
        set_dimensions(8'd3, 8'd1);
        issue_item(OP_WRITE, 7'd0, 7'd0, 32'd11, 3'd0);
        issue_item(OP_WRITE, 7'd0, 7'd1, 32'd22, 3'd0);
        issue_item(OP_WRITE, 7'd1, 7'd0, 32'd33, 3'd0);
        issue_item(OP_WRITE, 7'd1, 7'd1, 32'd44, 3'd0);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_VFLIP);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_HFLIP);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_ROT_CW);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_QUAD_CW);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, 3'd0);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_ROT_CCW);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, 3'd7);
        issue_item(OP_TRANSFORM, 7'd0, 7'd0, 32'h0, TR_QUAD_CCW);
        issue_item(OP_READ, 7'd0, 7'd0, 32'h0, 3'd0);
        issue_item(OP_READ, 7'd0, 7'd1, 32'h0, 3'd0);
        issue_item(OP_READ, 7'd1, 7'd0, 32'h0, 3'd0);
        issue_item(OP_READ, 7'd1, 7'd1, 32'h0, 3'd0);
        wait_until_settled();
    endtask

    task automatic test_random_traffic(input logic [7:0] rows, input logic [7:0] cols,
                                       input int idle_pct, input int count);
        set_dimensions(rows, cols);
        sender_idle_pct = idle_pct;
        for (int k = 0; k < count; k++) begin
            // Hold the sender once mid-phase until every result is back.
            if (k == count / 2) wait_until_settled();
            random_item();
        end
        wait_until_settled();
        sender_idle_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_size_corners();
        test_dimension_limits();
        test_transform_codes();
        test_random_traffic(8'd4, 8'd6, 0, 20);
        test_random_traffic(8'd8, 8'd2, 79, 20);
        test_random_traffic(8'd128, 8'd6, 36, 20);
        test_random_traffic(8'(2 * $urandom_range(1, 8)), 8'(2 * $urandom_range(1, 8)), 0, 20);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d commands (%0d writes, %0d reads, %0d transforms) under %0d %s",
                 item_count, write_count, read_count, transform_count, setting_count,
                 "dimension settings");
        $display("Checked %0d results with sender idle rates of 0, 36 and 79 percent.",
                 checked_count);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("PASS matrix_flip_rotate_engine");
        end else begin
            $display("FAIL matrix_flip_rotate_engine");
        end
        $finish;
    end

endmodule
